// ===== rtl/cbt_pkg.sv =====
// Shared types and constants for the CAN bit timing state machine.
`timescale 1ns / 1ps
`default_nettype none

package cbt_pkg;

  // Widths of configuration registers and counters
  localparam int unsigned Seg1LenW  = 5;
  localparam int unsigned Seg2LenW  = 4;
  localparam int unsigned JumpW     = 3;
  localparam int unsigned CntW      = 5;
  localparam int unsigned SegCodeW  = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SEG1_LEN   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SEG2_LEN   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_JUMP_WIDTH = 2'd2;

  // Reset values of the configuration registers
  localparam logic [Seg1LenW-1:0] SEG1_LEN_RST   = 5'd8;
  localparam logic [Seg2LenW-1:0] SEG2_LEN_RST   = 4'd7;
  localparam logic [JumpW-1:0]    JUMP_WIDTH_RST = 3'd1;

  // Segment codes as reported on the result word
  localparam logic [SegCodeW-1:0] SEG_SYNC   = 2'd0;
  localparam logic [SegCodeW-1:0] SEG_PSEG1  = 2'd1;
  localparam logic [SegCodeW-1:0] SEG_PSEG2  = 2'd2;
  localparam logic [SegCodeW-1:0] SEG_EXTEND = 2'd3;

  // Bit timing phase, one-hot
  typedef enum logic [3:0] {
    PH_SYNC   = 4'b0001,
    PH_PSEG1  = 4'b0010,
    PH_PSEG2  = 4'b0100,
    PH_EXTEND = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [Seg1LenW-1:0] seg1_len;
    logic [Seg2LenW-1:0] seg2_len;
    logic [JumpW-1:0]    jump_width;
  } cfg_t;

  typedef struct packed {
    phase_e          phase;
    logic [CntW-1:0] seg1_count;
    logic [CntW-1:0] seg2_count;
    logic [CntW-1:0] extend_left;
    logic            resync_pending;
    logic            hard_pending;
  } state_t;

  typedef struct packed {
    logic                sample_point;
    logic                write_point;
    logic [SegCodeW-1:0] segment;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/can_bit_timing_fsm_top.sv =====
// Top level of the CAN bit timing state machine: registers, handshakes, config.
//
// Usage: each input word is one time-quantum tick carrying edge_seen_i and
// hard_request_i. It is taken when in_valid_i and in_ready_o are both high.
// For every tick exactly one result word comes out (sample_point_o,
// write_point_o, segment_o), taken when out_valid_o and out_ready_i are high.
// Pipeline: a tick is held in the input register, the segment logic steps it
// into the result register, and its result is offered from there. Throughput:
// one tick per clock while out_ready_i is high; the single segment step between
// the input and result registers sets that figure.
// Stall: while a result waits, one more tick can be held in the input
// register; in_ready_o drops only when both registers are full.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 seg1_len, 1 seg2_len, 2 jump_width) at once; write only when idle.
// Reset: rst_ni clears both registers' valid flags, puts the machine in the
// sync segment with zero counters, and loads the default timing.
`timescale 1ns / 1ps
`default_nettype none

module can_bit_timing_fsm_top (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [cbt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire [cbt_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire                           edge_seen_i,
  input  wire                           hard_request_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic                          sample_point_o,
  output logic                          write_point_o,
  output logic [cbt_pkg::SegCodeW-1:0]  segment_o
);

  cbt_pkg::cfg_t    cfg_q;
  cbt_pkg::state_t  state_q;
  cbt_pkg::state_t  state_d;
  cbt_pkg::result_t res_d;
  cbt_pkg::result_t res_q;
  logic             in_valid_q;
  logic             edge_q;
  logic             hard_q;
  logic             out_valid_q;
  logic             step_fire;
  logic             in_fire;

  assign step_fire  = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | step_fire;
  assign in_fire    = in_valid_i & in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seg1_len   <= cbt_pkg::SEG1_LEN_RST;
      cfg_q.seg2_len   <= cbt_pkg::SEG2_LEN_RST;
      cfg_q.jump_width <= cbt_pkg::JUMP_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cbt_pkg::CFG_SEG1_LEN:   cfg_q.seg1_len   <= cfg_wdata_i[cbt_pkg::Seg1LenW-1:0];
        cbt_pkg::CFG_SEG2_LEN:   cfg_q.seg2_len   <= cfg_wdata_i[cbt_pkg::Seg2LenW-1:0];
        cbt_pkg::CFG_JUMP_WIDTH: cfg_q.jump_width <= cfg_wdata_i[cbt_pkg::JumpW-1:0];
        default: ;
      endcase
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      edge_q <= edge_seen_i;
      hard_q <= hard_request_i;
    end
  end

  cbt_step u_step (
    .cfg_i          (cfg_q),
    .state_i        (state_q),
    .edge_seen_i    (edge_q),
    .hard_request_i (hard_q),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  // Timing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= cbt_pkg::PH_SYNC;
      state_q.seg1_count     <= '0;
      state_q.seg2_count     <= '0;
      state_q.extend_left    <= '0;
      state_q.resync_pending <= 1'b0;
      state_q.hard_pending   <= 1'b0;
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_point_o = res_q.sample_point;
  assign write_point_o  = res_q.write_point;
  assign segment_o      = res_q.segment;

  // Sample and write points never share a tick
  a_no_sample_and_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(sample_point_o && write_point_o))
    else $error("sample and write point on one tick");

  // Sample point always hands over to phase segment two
  a_sample_to_pseg2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sample_point_o) |-> (segment_o == cbt_pkg::SEG_PSEG2))
    else $error("sample point not followed by phase segment two");

  // Write point always ends the bit
  a_write_to_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && write_point_o) |-> (segment_o == cbt_pkg::SEG_SYNC))
    else $error("write point not followed by sync segment");

  // Input side stalls only when both registers are full and output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

// ===== rtl/cbt_step.sv =====
// Next-state and result logic for one time-quantum tick.
`timescale 1ns / 1ps
`default_nettype none

module cbt_step (
  input  var cbt_pkg::cfg_t    cfg_i,
  input  var cbt_pkg::state_t  state_i,
  input  wire                  edge_seen_i,
  input  wire                  hard_request_i,
  output cbt_pkg::state_t      state_o,
  output cbt_pkg::result_t     result_o
);

  logic                       resync;
  logic                       hard;
  logic [cbt_pkg::CntW-1:0]   cnt1_inc;
  logic [cbt_pkg::CntW-1:0]   cnt2_inc;
  logic [cbt_pkg::CntW-1:0]   ext_dec;
  logic signed [cbt_pkg::CntW:0] rem1;
  logic signed [cbt_pkg::CntW:0] rem2;
  logic signed [cbt_pkg::CntW:0] jw_s;
  logic [cbt_pkg::CntW-1:0]   jw_cnt;

  // Pending flags latch before stepping
  assign resync   = state_i.resync_pending | edge_seen_i;
  assign hard     = state_i.hard_pending | hard_request_i;
  assign cnt1_inc = state_i.seg1_count + cbt_pkg::CntW'(1'b1);
  assign cnt2_inc = state_i.seg2_count + cbt_pkg::CntW'(1'b1);
  assign ext_dec  = state_i.extend_left - cbt_pkg::CntW'(1'b1);
  assign jw_cnt   = {2'b00, cfg_i.jump_width};
  assign jw_s     = $signed({1'b0, jw_cnt});
  // Remaining length, signed
  assign rem1 = $signed({1'b0, cfg_i.seg1_len}) - $signed({1'b0, cnt1_inc});
  assign rem2 = $signed({2'b00, cfg_i.seg2_len}) - $signed({1'b0, cnt2_inc});

  // Segment step and segment code after the step
  always_comb begin
    state_o                = state_i;
    state_o.resync_pending = resync;
    state_o.hard_pending   = hard;
    result_o.sample_point  = 1'b0;
    result_o.write_point   = 1'b0;
    case (state_i.phase)
      cbt_pkg::PH_SYNC: begin
        if (hard) begin
          state_o.seg1_count   = '0;
          state_o.seg2_count   = '0;
          state_o.hard_pending = 1'b0;
        end
        state_o.resync_pending = 1'b0;
        state_o.phase          = cbt_pkg::PH_PSEG1;
      end
      cbt_pkg::PH_PSEG1: begin
        state_o.seg1_count = cnt1_inc;
        if (cnt1_inc == cfg_i.seg1_len) begin
          state_o.seg1_count    = '0;
          result_o.sample_point = 1'b1;
          state_o.phase         = cbt_pkg::PH_PSEG2;
        end else if (resync) begin
          state_o.resync_pending = 1'b0;
          state_o.extend_left    = (rem1 < jw_s) ? jw_cnt : rem1[cbt_pkg::CntW-1:0];
          state_o.seg1_count     = '0;
          state_o.phase          = cbt_pkg::PH_EXTEND;
        end
      end
      cbt_pkg::PH_EXTEND: begin
        state_o.extend_left    = ext_dec;
        state_o.resync_pending = 1'b0;
        if (ext_dec == '0) begin
          result_o.sample_point = 1'b1;
          state_o.phase         = cbt_pkg::PH_PSEG2;
        end
      end
      cbt_pkg::PH_PSEG2: begin
        state_o.seg2_count = cnt2_inc;
        if (cnt2_inc >= {1'b0, cfg_i.seg2_len}) begin
          state_o.seg2_count   = '0;
          result_o.write_point = 1'b1;
          state_o.phase        = cbt_pkg::PH_SYNC;
        end else if (resync) begin
          state_o.resync_pending = 1'b0;
          if (rem2 < jw_s) begin
            // push the counter ahead by the jump width
            state_o.seg2_count = cnt2_inc + jw_cnt;
          end else begin
            state_o.seg2_count   = '0;
            result_o.write_point = 1'b1;
            state_o.phase        = cbt_pkg::PH_SYNC;
          end
        end
      end
      default: begin
        state_o.phase = cbt_pkg::PH_SYNC;
      end
    endcase
    case (state_o.phase)
      cbt_pkg::PH_SYNC:   result_o.segment = cbt_pkg::SEG_SYNC;
      cbt_pkg::PH_PSEG1:  result_o.segment = cbt_pkg::SEG_PSEG1;
      cbt_pkg::PH_PSEG2:  result_o.segment = cbt_pkg::SEG_PSEG2;
      cbt_pkg::PH_EXTEND: result_o.segment = cbt_pkg::SEG_EXTEND;
      default:            result_o.segment = cbt_pkg::SEG_SYNC;
    endcase
  end

endmodule

`default_nettype wire
